// ===== rtl/core/tvsp_pkg.sv =====
// Shared types and constants of the tagged value stream parser.
`default_nettype none
package tvsp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CNT_VAR, PH_OFFSIZE, PH_SKIP, PH_KEY, PH_VALUE, PH_REF_VAR,
    PH_CUST_VAR, PH_CLEN, PH_OLEN, PH_FIXED, PH_PAYLOAD
  } phase_t;

  typedef enum logic [3:0] {
    TK_LIST, TK_OBJECT, TK_KEY, TK_NULL, TK_BOOL, TK_INT, TK_BYTE, TK_F32, TK_F64,
    TK_REF, TK_STR, TK_COMP, TK_CUSTOM, TK_PAYLOAD, TK_ERROR
  } kind_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_KEY     = 2'd1;
  localparam logic [1:0] ERR_CUSTOM  = 2'd2;
  localparam logic [1:0] ERR_SUBTYPE = 2'd3;

  localparam logic [2:0] REG_DICT_SIZE  = 3'd0;
  localparam logic [2:0] REG_CUST_A     = 3'd1;
  localparam logic [2:0] REG_CUST_B     = 3'd2;
  localparam logic [2:0] REG_CUST_C     = 3'd3;
  localparam logic [2:0] REG_CUST_D     = 3'd4;
  localparam logic [2:0] REG_CUST_MASK  = 3'd5;

  localparam logic [6:0] VAR_MARK   = 7'h7F;
  localparam logic [3:0] SUB_NULL   = 4'hC;
  localparam logic [3:0] SUB_BYTE   = 4'hD;
  localparam logic [3:0] SUB_FALSE  = 4'hE;
  localparam logic [3:0] SUB_TRUE   = 4'hF;
  localparam logic [3:0] SUB_F32    = 4'h8;
  localparam logic [3:0] SUB_F64    = 4'h9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       entity_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [63:0] token_aux;
    logic [1:0]  error_code;
    logic        entity_last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] dictionary_size;
    logic [7:0]  custom_size_a;
    logic [7:0]  custom_size_b;
    logic [7:0]  custom_size_c;
    logic [7:0]  custom_size_d;
    logic [3:0]  custom_valid_mask;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_object;
    logic [63:0] elements_left;
    logic [63:0] skip_left;
    logic [63:0] acc;
    logic [6:0]  bytes_left;
    logic [6:0]  byte_index;
    logic [63:0] payload_left;
    logic [3:0]  subtype;
    logic [63:0] comp_len;
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/tvsp_step.sv =====
// Next-state and token logic for one stream byte.
`default_nettype none
module tvsp_step #(
  parameter int CUSTOM_IDS = 4
) (
  input  tvsp_pkg::state_t   cur,
  input  tvsp_pkg::cfg_t     cfg,
  input  tvsp_pkg::in_item_t item,
  output tvsp_pkg::state_t   nxt,
  output logic               emit,
  output tvsp_pkg::out_item_t tok
);

  typedef struct packed {
    logic        done;
    logic [63:0] acc;
    logic [6:0]  left;
    logic [6:0]  idx;
  } feed_t;

  function automatic logic [63:0] put_byte(logic [63:0] acc, logic [7:0] b,
                                           logic [6:0] idx);
    logic [63:0] r;
    r = acc;
    if (idx < 7'd8) r[idx[2:0]*8 +: 8] = r[idx[2:0]*8 +: 8] | b;
    return r;
  endfunction

  function automatic feed_t var_feed(tvsp_pkg::state_t s, logic [7:0] b);
    feed_t f;
    f.acc = s.acc; f.left = s.bytes_left; f.idx = s.byte_index; f.done = 1'b0;
    if (s.bytes_left == 7'd0) begin
      f.acc = '0; f.idx = '0;
      if (!b[7]) begin
        f.acc = {56'd0, b}; f.done = 1'b1;
      end else begin
        f.left = b[6:0]; f.done = (b[6:0] == 7'd0);
      end
    end else begin
      f.acc = put_byte(s.acc, b, s.byte_index);
      if (s.byte_index != 7'd127) f.idx = s.byte_index + 7'd1;
      f.left = s.bytes_left - 7'd1;
      f.done = (f.left == 7'd0);
    end
    return f;
  endfunction

  logic [7:0]  b;
  logic [3:0]  sub;
  feed_t       fd;
  logic        done, pay, fail, cust;
  logic [63:0] pay_n, cust_id, sz, el_dec;
  logic [3:0]  kind;
  logic [63:0] val, aux;
  logic [1:0]  ecode;

  assign b   = item.data_byte;
  assign sub = b[3:0];
  assign fd  = var_feed(cur, b);

  always_comb begin
    nxt = cur;
    emit = 1'b0; done = 1'b0; pay = 1'b0; fail = 1'b0; cust = 1'b0;
    pay_n = '0; cust_id = '0; sz = '0; el_dec = '0;
    kind = tvsp_pkg::TK_NULL; val = '0; aux = '0; ecode = tvsp_pkg::ERR_NONE;
    tok = '0;

    if (item.entity_start) begin
      nxt.is_object = ~b[7];
      nxt.elements_left = {57'd0, b[6:0]};
      nxt.skip_left = '0; nxt.payload_left = '0;
      nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
      nxt.phase = (b[6:0] == tvsp_pkg::VAR_MARK) ? tvsp_pkg::PH_CNT_VAR
                                                   : tvsp_pkg::PH_OFFSIZE;
    end else begin
      case (cur.phase)
        tvsp_pkg::PH_CNT_VAR: begin
          nxt.acc = fd.acc; nxt.bytes_left = fd.left; nxt.byte_index = fd.idx;
          if (fd.done) begin
            nxt.elements_left = fd.acc; nxt.phase = tvsp_pkg::PH_OFFSIZE;
          end
        end
        tvsp_pkg::PH_OFFSIZE: begin
          nxt.skip_left = cur.elements_left * {56'd0, b};
          emit = 1'b1;
          tok.token_kind = cur.is_object ? tvsp_pkg::TK_OBJECT : tvsp_pkg::TK_LIST;
          if (cur.elements_left == '0) begin
            nxt.phase = tvsp_pkg::PH_IDLE; tok.entity_last = 1'b1;
          end else begin
            tok.token_value = cur.elements_left;
            if (nxt.skip_left != '0) nxt.phase = tvsp_pkg::PH_SKIP;
            else begin
              nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
              nxt.phase = cur.is_object ? tvsp_pkg::PH_KEY : tvsp_pkg::PH_VALUE;
            end
          end
        end
        tvsp_pkg::PH_SKIP: begin
          nxt.skip_left = cur.skip_left - 64'd1;
          if (nxt.skip_left == '0) begin
            nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
            nxt.phase = cur.is_object ? tvsp_pkg::PH_KEY : tvsp_pkg::PH_VALUE;
          end
        end
        tvsp_pkg::PH_KEY: begin
          nxt.acc = fd.acc; nxt.bytes_left = fd.left; nxt.byte_index = fd.idx;
          if (fd.done) begin
            if (fd.acc >= {48'd0, cfg.dictionary_size}) begin
              fail = 1'b1; ecode = tvsp_pkg::ERR_KEY; val = fd.acc;
            end else begin
              nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
              nxt.phase = tvsp_pkg::PH_VALUE;
              emit = 1'b1; tok.token_kind = tvsp_pkg::TK_KEY; tok.token_value = fd.acc;
            end
          end
        end
        tvsp_pkg::PH_VALUE: begin
          if (!b[7]) begin
            if (b[6:0] == tvsp_pkg::VAR_MARK) begin
              nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
              nxt.phase = tvsp_pkg::PH_CLEN;
            end else begin
              pay = 1'b1; kind = tvsp_pkg::TK_STR; val = {57'd0, b[6:0]}; pay_n = val;
            end
          end else if (b[7:6] == 2'b10) begin
            if (b[4:0] == 5'h1F) begin
              nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
              nxt.phase = tvsp_pkg::PH_REF_VAR;
            end else begin
              done = 1'b1; kind = tvsp_pkg::TK_REF; val = {59'd0, b[4:0]};
            end
          end else if (b[7:4] == 4'hC) begin
            done = 1'b1; kind = tvsp_pkg::TK_INT; val = {60'd0, sub};
          end else if (b[7:4] == 4'hD) begin
            done = 1'b1; kind = tvsp_pkg::TK_INT; val = 64'd0 - {60'd0, sub};
          end else if (b[7:4] == 4'hE) begin
            if (sub == 4'hF) begin
              nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
              nxt.phase = tvsp_pkg::PH_CUST_VAR;
            end else begin
              cust = 1'b1; cust_id = {60'd0, sub};
            end
          end else if (sub == tvsp_pkg::SUB_NULL) begin
            done = 1'b1; kind = tvsp_pkg::TK_NULL;
          end else if (sub == tvsp_pkg::SUB_FALSE) begin
            done = 1'b1; kind = tvsp_pkg::TK_BOOL;
          end else if (sub == tvsp_pkg::SUB_TRUE) begin
            done = 1'b1; kind = tvsp_pkg::TK_BOOL; val = 64'd1;
          end else if (sub == tvsp_pkg::SUB_BYTE || sub <= 4'd7 ||
                       sub == tvsp_pkg::SUB_F32 || sub == tvsp_pkg::SUB_F64) begin
            nxt.acc = '0; nxt.byte_index = '0; nxt.subtype = sub;
            nxt.phase = tvsp_pkg::PH_FIXED;
            if (sub == tvsp_pkg::SUB_BYTE)     nxt.bytes_left = 7'd1;
            else if (sub == tvsp_pkg::SUB_F32) nxt.bytes_left = 7'd4;
            else if (sub == tvsp_pkg::SUB_F64) nxt.bytes_left = 7'd8;
            else nxt.bytes_left = 7'd1 << sub[1:0];
          end else begin
            fail = 1'b1; ecode = tvsp_pkg::ERR_SUBTYPE; val = {60'd0, sub};
          end
        end
        tvsp_pkg::PH_REF_VAR: begin
          nxt.acc = fd.acc; nxt.bytes_left = fd.left; nxt.byte_index = fd.idx;
          if (fd.done) begin
            done = 1'b1; kind = tvsp_pkg::TK_REF; val = fd.acc;
          end
        end
        tvsp_pkg::PH_CUST_VAR: begin
          nxt.acc = fd.acc; nxt.bytes_left = fd.left; nxt.byte_index = fd.idx;
          if (fd.done) begin
            cust = 1'b1; cust_id = fd.acc;
          end
        end
        tvsp_pkg::PH_CLEN: begin
          nxt.acc = fd.acc; nxt.bytes_left = fd.left; nxt.byte_index = fd.idx;
          if (fd.done) begin
            nxt.comp_len = fd.acc;
            nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
            nxt.phase = tvsp_pkg::PH_OLEN;
          end
        end
        tvsp_pkg::PH_OLEN: begin
          nxt.acc = fd.acc; nxt.bytes_left = fd.left; nxt.byte_index = fd.idx;
          if (fd.done) begin
            pay = 1'b1; kind = tvsp_pkg::TK_COMP; val = cur.comp_len;
            aux = fd.acc; pay_n = cur.comp_len;
          end
        end
        tvsp_pkg::PH_FIXED: begin
          nxt.acc = put_byte(cur.acc, b, cur.byte_index);
          nxt.byte_index = cur.byte_index + 7'd1;
          if (cur.bytes_left != 7'd0) nxt.bytes_left = cur.bytes_left - 7'd1;
          if (nxt.bytes_left == 7'd0) begin
            done = 1'b1; val = nxt.acc;
            if (cur.subtype == tvsp_pkg::SUB_BYTE)     kind = tvsp_pkg::TK_BYTE;
            else if (cur.subtype == tvsp_pkg::SUB_F32) kind = tvsp_pkg::TK_F32;
            else if (cur.subtype == tvsp_pkg::SUB_F64) kind = tvsp_pkg::TK_F64;
            else begin
              kind = tvsp_pkg::TK_INT;
              if (cur.subtype[2]) val = 64'd0 - nxt.acc;
            end
          end
        end
        tvsp_pkg::PH_PAYLOAD: begin
          nxt.payload_left = cur.payload_left - 64'd1;
          kind = tvsp_pkg::TK_PAYLOAD; val = {56'd0, b};
          if (nxt.payload_left == '0) done = 1'b1;
          else begin
            emit = 1'b1; tok.token_kind = kind; tok.token_value = val;
          end
        end
        default: ;
      endcase
    end

    // Custom header: check the id, then start its payload or close an empty one
    if (cust) begin
      if (cust_id >= 64'(CUSTOM_IDS) || cust_id >= 64'd4 ||
          !cfg.custom_valid_mask[cust_id[1:0]]) begin
        fail = 1'b1; ecode = tvsp_pkg::ERR_CUSTOM; val = cust_id;
      end else begin
        case (cust_id[1:0])
          2'd0:    sz = {56'd0, cfg.custom_size_a};
          2'd1:    sz = {56'd0, cfg.custom_size_b};
          2'd2:    sz = {56'd0, cfg.custom_size_c};
          default: sz = {56'd0, cfg.custom_size_d};
        endcase
        pay = 1'b1; kind = tvsp_pkg::TK_CUSTOM; val = sz; aux = cust_id; pay_n = sz;
      end
    end

    if (pay) begin
      if (pay_n == '0) done = 1'b1;
      else begin
        nxt.payload_left = pay_n; nxt.phase = tvsp_pkg::PH_PAYLOAD;
        emit = 1'b1; tok.token_kind = kind; tok.token_value = val; tok.token_aux = aux;
      end
    end

    if (done) begin
      el_dec = cur.elements_left - 64'd1;
      nxt.elements_left = el_dec;
      emit = 1'b1; tok.token_kind = kind; tok.token_value = val; tok.token_aux = aux;
      if (el_dec == '0) begin
        nxt.phase = tvsp_pkg::PH_IDLE; tok.entity_last = 1'b1;
      end else begin
        nxt.acc = '0; nxt.bytes_left = '0; nxt.byte_index = '0;
        nxt.phase = cur.is_object ? tvsp_pkg::PH_KEY : tvsp_pkg::PH_VALUE;
      end
    end

    if (fail) begin
      nxt.phase = tvsp_pkg::PH_IDLE; nxt.elements_left = '0;
      emit = 1'b1;
      tok = '0;
      tok.token_kind = tvsp_pkg::TK_ERROR; tok.token_value = val;
      tok.error_code = ecode; tok.entity_last = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tagged_value_stream_parser.sv =====
// Top level of the tagged value stream parser: registers, handshake and config.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall  | in_item_t: data_byte, entity_start
//  out_    | output    | out_valid/out_stall| out_item_t: one token
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low; its token (if any)
// appears in the output register on the next cycle, set by the single parse
// step between the state and result registers. Reset (rst_n low, synchronous)
// returns to idle and clears the configuration. A stalled output register holds
// its transaction and back-pressures the input only while it is full and stalled.
`default_nettype none
module tagged_value_stream_parser #(
  parameter int CUSTOM_IDS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tvsp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tvsp_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  tvsp_pkg::state_t    state_r, state_nxt;
  tvsp_pkg::cfg_t      cfg_r;
  tvsp_pkg::out_item_t out_r, tok;
  logic                out_valid_r, emit, accept;

  // Hold the input back only while a finished token waits on a stalled sink
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tvsp_step #(.CUSTOM_IDS(CUSTOM_IDS)) u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (in_data),
    .nxt  (state_nxt),
    .emit (emit),
    .tok  (tok)
  );

  // The all-zero state is idle with every counter cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) state_r <= state_nxt;
      // Load a new transaction, or drop the one the sink has just taken
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) out_r <= tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tvsp_pkg::REG_DICT_SIZE: cfg_r.dictionary_size   <= cfg_data;
        tvsp_pkg::REG_CUST_A:    cfg_r.custom_size_a     <= cfg_data[7:0];
        tvsp_pkg::REG_CUST_B:    cfg_r.custom_size_b     <= cfg_data[7:0];
        tvsp_pkg::REG_CUST_C:    cfg_r.custom_size_c     <= cfg_data[7:0];
        tvsp_pkg::REG_CUST_D:    cfg_r.custom_size_d     <= cfg_data[7:0];
        tvsp_pkg::REG_CUST_MASK: cfg_r.custom_valid_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/tagged_value_stream_parser_test.sv =====
// Testbench of the tagged value stream parser: token prediction and checking.
`timescale 1ns / 100ps
module tagged_value_stream_parser_test;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tvsp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tvsp_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  tagged_value_stream_parser u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor copy of the configuration and parse state.
  logic [15:0]       dict_size;
  logic [7:0]        cust_size [4];
  logic [3:0]        cust_mask;
  tvsp_pkg::phase_t  phase;
  logic              obj;
  logic [63:0]       elems, skip, acc, pay_left, comp_len;
  logic [6:0]        nb_left, nb_idx;
  logic [3:0]        subtype;

  tvsp_pkg::in_item_t  byte_queue [$];
  tvsp_pkg::out_item_t token_queue [$];
  int        errors;
  int        tokens_seen;
  int        send_idle_pct;
  int        stall_pct;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h (token %0d)", what, got, want, tokens_seen);
    errors++;
  endtask

  task automatic add_byte(input tvsp_pkg::in_item_t it);
    byte_queue = {byte_queue, it};
  endtask

  task automatic push_token(input tvsp_pkg::kind_t k, input logic [63:0] v,
                            input logic [63:0] aux, input logic [1:0] err,
                            input logic last);
    tvsp_pkg::out_item_t t;
    t.token_kind = k;
    t.token_value = v;
    t.token_aux = aux;
    t.error_code = err;
    t.entity_last = last;
    token_queue = {token_queue, t};
  endtask

  function automatic void clear_num();
    acc = '0;
    nb_left = '0;
    nb_idx = '0;
  endfunction

  task automatic fail_entity(input logic [1:0] code, input logic [63:0] v);
    phase = tvsp_pkg::PH_IDLE;
    elems = '0;
    push_token(tvsp_pkg::TK_ERROR, v, '0, code, 1'b1);
  endtask

  // Close one element; the last one closes the entity.
  task automatic element_done(input tvsp_pkg::kind_t k, input logic [63:0] v,
                              input logic [63:0] aux);
    elems = elems - 64'd1;
    if (elems == 0) begin
      phase = tvsp_pkg::PH_IDLE;
      push_token(k, v, aux, tvsp_pkg::ERR_NONE, 1'b1);
    end else begin
      clear_num();
      phase = obj ? tvsp_pkg::PH_KEY : tvsp_pkg::PH_VALUE;
      push_token(k, v, aux, tvsp_pkg::ERR_NONE, 1'b0);
    end
  endtask

  task automatic open_payload(input tvsp_pkg::kind_t k, input logic [63:0] v,
                              input logic [63:0] aux, input logic [63:0] n);
    if (n == 0) begin
      element_done(k, v, aux);
    end else begin
      pay_left = n;
      phase = tvsp_pkg::PH_PAYLOAD;
      push_token(k, v, aux, tvsp_pkg::ERR_NONE, 1'b0);
    end
  endtask

  // Feed one byte of a variable number; returns 1 once it is complete.
  function automatic bit varnum_feed(input logic [7:0] b);
    if (nb_left == 0) begin
      acc = '0;
      nb_idx = '0;
      if (!b[7]) begin
        acc = {56'd0, b};
        return 1'b1;
      end
      nb_left = b[6:0];
      return nb_left == 0;
    end
    if (nb_idx < 7'd8) acc = acc | ({56'd0, b} << (8 * nb_idx));
    if (nb_idx < 7'd127) nb_idx = nb_idx + 7'd1;
    nb_left = nb_left - 7'd1;
    return nb_left == 0;
  endfunction

  task automatic custom_open(input logic [63:0] id);
    if (id >= 64'd4 || !cust_mask[id[1:0]]) begin
      fail_entity(tvsp_pkg::ERR_CUSTOM, id);
    end else begin
      open_payload(tvsp_pkg::TK_CUSTOM, {56'd0, cust_size[id[1:0]]}, id,
                   {56'd0, cust_size[id[1:0]]});
    end
  endtask

  task automatic start_fixed(input int len, input logic [3:0] sub);
    clear_num();
    nb_left = len[6:0];
    subtype = sub;
    phase = tvsp_pkg::PH_FIXED;
  endtask

  task automatic decode_tag(input logic [7:0] b);
    logic [3:0] sub;
    sub = b[3:0];
    if (!b[7]) begin
      if (b[6:0] == tvsp_pkg::VAR_MARK) begin
        clear_num();
        phase = tvsp_pkg::PH_CLEN;
      end else begin
        open_payload(tvsp_pkg::TK_STR, {57'd0, b[6:0]}, '0, {57'd0, b[6:0]});
      end
    end else if (b[7:6] == 2'b10) begin
      if (b[4:0] == 5'h1F) begin
        clear_num();
        phase = tvsp_pkg::PH_REF_VAR;
      end else begin
        element_done(tvsp_pkg::TK_REF, {59'd0, b[4:0]}, '0);
      end
    end else if (b[7:4] == 4'hC) begin
      element_done(tvsp_pkg::TK_INT, {60'd0, sub}, '0);
    end else if (b[7:4] == 4'hD) begin
      element_done(tvsp_pkg::TK_INT, 64'd0 - {60'd0, sub}, '0);
    end else if (b[7:4] == 4'hE) begin
      if (sub == 4'hF) begin
        clear_num();
        phase = tvsp_pkg::PH_CUST_VAR;
      end else begin
        custom_open({60'd0, sub});
      end
    end else if (sub == tvsp_pkg::SUB_NULL) begin
      element_done(tvsp_pkg::TK_NULL, '0, '0);
    end else if (sub == tvsp_pkg::SUB_FALSE) begin
      element_done(tvsp_pkg::TK_BOOL, '0, '0);
    end else if (sub == tvsp_pkg::SUB_TRUE) begin
      element_done(tvsp_pkg::TK_BOOL, 64'd1, '0);
    end else if (sub == tvsp_pkg::SUB_BYTE) begin
      start_fixed(1, sub);
    end else if (sub <= 4'h7) begin
      start_fixed(1 << sub[1:0], sub);
    end else if (sub == tvsp_pkg::SUB_F32) begin
      start_fixed(4, sub);
    end else if (sub == tvsp_pkg::SUB_F64) begin
      start_fixed(8, sub);
    end else begin
      fail_entity(tvsp_pkg::ERR_SUBTYPE, {60'd0, sub});
    end
  endtask

  task automatic element_done_or_byte(input logic [7:0] b);
    if (pay_left == 0) element_done(tvsp_pkg::TK_PAYLOAD, {56'd0, b}, '0);
    else push_token(tvsp_pkg::TK_PAYLOAD, {56'd0, b}, '0, tvsp_pkg::ERR_NONE, 1'b0);
  endtask

  // Advance the predictor by one accepted byte.
  task automatic predict_tokens(input tvsp_pkg::in_item_t it);
    logic [7:0]  b;
    logic [63:0] v;
    b = it.data_byte;
    if (it.entity_start) begin
      obj = !b[7];
      elems = {57'd0, b[6:0]};
      skip = '0;
      pay_left = '0;
      clear_num();
      phase = (b[6:0] == tvsp_pkg::VAR_MARK) ? tvsp_pkg::PH_CNT_VAR : tvsp_pkg::PH_OFFSIZE;
      return;
    end
    case (phase)
      tvsp_pkg::PH_CNT_VAR: begin
        if (varnum_feed(b)) begin
          elems = acc;
          phase = tvsp_pkg::PH_OFFSIZE;
        end
      end
      tvsp_pkg::PH_OFFSIZE: begin
        skip = {56'd0, b} * elems;
        if (elems == 0) begin
          phase = tvsp_pkg::PH_IDLE;
          push_token(obj ? tvsp_pkg::TK_OBJECT : tvsp_pkg::TK_LIST, '0, '0,
                     tvsp_pkg::ERR_NONE, 1'b1);
        end else begin
          if (skip != 0) begin
            phase = tvsp_pkg::PH_SKIP;
          end else begin
            clear_num();
            phase = obj ? tvsp_pkg::PH_KEY : tvsp_pkg::PH_VALUE;
          end
          push_token(obj ? tvsp_pkg::TK_OBJECT : tvsp_pkg::TK_LIST, elems, '0,
                     tvsp_pkg::ERR_NONE, 1'b0);
        end
      end
      tvsp_pkg::PH_SKIP: begin
        skip = skip - 64'd1;
        if (skip == 0) begin
          clear_num();
          phase = obj ? tvsp_pkg::PH_KEY : tvsp_pkg::PH_VALUE;
        end
      end
      tvsp_pkg::PH_KEY: begin
        if (varnum_feed(b)) begin
          v = acc;
          if (v >= {48'd0, dict_size}) begin
            fail_entity(tvsp_pkg::ERR_KEY, v);
          end else begin
            clear_num();
            phase = tvsp_pkg::PH_VALUE;
            push_token(tvsp_pkg::TK_KEY, v, '0, tvsp_pkg::ERR_NONE, 1'b0);
          end
        end
      end
      tvsp_pkg::PH_VALUE: decode_tag(b);
      tvsp_pkg::PH_REF_VAR: if (varnum_feed(b)) element_done(tvsp_pkg::TK_REF, acc, '0);
      tvsp_pkg::PH_CUST_VAR: if (varnum_feed(b)) custom_open(acc);
      tvsp_pkg::PH_CLEN: begin
        if (varnum_feed(b)) begin
          comp_len = acc;
          clear_num();
          phase = tvsp_pkg::PH_OLEN;
        end
      end
      tvsp_pkg::PH_OLEN: begin
        if (varnum_feed(b)) open_payload(tvsp_pkg::TK_COMP, comp_len, acc, comp_len);
      end
      tvsp_pkg::PH_FIXED: begin
        if (nb_idx < 7'd8) acc = acc | ({56'd0, b} << (8 * nb_idx));
        nb_idx = nb_idx + 7'd1;
        if (nb_left != 0) nb_left = nb_left - 7'd1;
        if (nb_left == 0) begin
          v = acc;
          if (subtype == tvsp_pkg::SUB_BYTE) element_done(tvsp_pkg::TK_BYTE, v, '0);
          else if (subtype == tvsp_pkg::SUB_F32) element_done(tvsp_pkg::TK_F32, v, '0);
          else if (subtype == tvsp_pkg::SUB_F64) element_done(tvsp_pkg::TK_F64, v, '0);
          else element_done(tvsp_pkg::TK_INT, subtype[2] ? 64'd0 - v : v, '0);
        end
      end
      tvsp_pkg::PH_PAYLOAD: begin
        pay_left = pay_left - 64'd1;
        element_done_or_byte(b);
      end
      default: ;
    endcase
  endtask

  // Driver: hold the transaction while stalled, advance on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_tokens(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted token against the oldest prediction.
  always @(posedge clk) begin
    tvsp_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (token_queue.size() == 0) begin
          report_mismatch("unexpected token kind", 64'(out_data.token_kind), 64'd0);
        end else begin
          want = token_queue.pop_front();
          if (out_data.token_kind != want.token_kind)
            report_mismatch("token_kind", 64'(out_data.token_kind), 64'(want.token_kind));
          if (out_data.token_value != want.token_value)
            report_mismatch("token_value", out_data.token_value, want.token_value);
          if (out_data.token_aux != want.token_aux)
            report_mismatch("token_aux", out_data.token_aux, want.token_aux);
          if (out_data.error_code != want.error_code)
            report_mismatch("error_code", 64'(out_data.error_code), 64'(want.error_code));
          if (out_data.entity_last != want.entity_last)
            report_mismatch("entity_last", 64'(out_data.entity_last),
                            64'(want.entity_last));
        end
        tokens_seen++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic tvsp_pkg::in_item_t mk(input logic [7:0] b, input logic s = 1'b0);
    tvsp_pkg::in_item_t it;
    it.data_byte = b;
    it.entity_start = s;
    return it;
  endfunction

  // Drain: wait for the driver to empty its queue and all tokens to arrive.
  task automatic drain();
    while (byte_queue.size() > 0 || in_valid) @(posedge clk);
    repeat (2) @(posedge clk);
    while (token_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tvsp_pkg::REG_DICT_SIZE: dict_size = val;
      tvsp_pkg::REG_CUST_A:    cust_size[0] = val[7:0];
      tvsp_pkg::REG_CUST_B:    cust_size[1] = val[7:0];
      tvsp_pkg::REG_CUST_C:    cust_size[2] = val[7:0];
      tvsp_pkg::REG_CUST_D:    cust_size[3] = val[7:0];
      tvsp_pkg::REG_CUST_MASK: cust_mask = val[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] d, input logic [7:0] a, input logic [7:0] bb,
                           input logic [7:0] c, input logic [7:0] e, input logic [3:0] m);
    write_reg(tvsp_pkg::REG_DICT_SIZE, d);
    write_reg(tvsp_pkg::REG_CUST_A, {8'd0, a});
    write_reg(tvsp_pkg::REG_CUST_B, {8'd0, bb});
    write_reg(tvsp_pkg::REG_CUST_C, {8'd0, c});
    write_reg(tvsp_pkg::REG_CUST_D, {8'd0, e});
    write_reg(tvsp_pkg::REG_CUST_MASK, {12'd0, m});
  endtask

  // Append one tagged value with random content; mostly well formed.
  task automatic queue_value();
    int k, n, i;
    k = $urandom_range(13);
    case (k)
      0: begin
        n = $urandom_range(4);
        add_byte(mk(n[7:0]));
        for (i = 0; i < n; i++) add_byte(mk(8'($urandom_range(255))));
      end
      1: add_byte(mk(8'h80 | 8'($urandom_range(63))));
      2: begin
        add_byte(mk(8'h9F));
        add_byte(mk(8'h80 | 8'($urandom_range(10))));
        for (i = 0; i < 10; i++) add_byte(mk(8'($urandom_range(255))));
      end
      3: add_byte(mk(8'hC0 | 8'($urandom_range(31))));
      4: begin
        n = $urandom_range(7);
        add_byte(mk(8'hF0 | n[7:0]));
        for (i = 0; i < (1 << (n % 4)); i++) add_byte(mk(8'($urandom_range(255))));
      end
      5: begin
        n = $urandom_range(8, 9);
        add_byte(mk(8'hF0 | n[7:0]));
        for (i = 0; i < (n == 8 ? 4 : 8); i++) add_byte(mk(8'($urandom_range(255))));
      end
      6: begin
        add_byte(mk(8'hFD));
        add_byte(mk(8'($urandom_range(255))));
      end
      7: add_byte(mk(8'hFC | 8'($urandom_range(3))));
      8: begin
        add_byte(mk(8'hE0 | 8'($urandom_range(4))));
        for (i = 0; i < 4; i++) add_byte(mk(8'($urandom_range(255))));
      end
      9: begin
        add_byte(mk(8'hEF));
        add_byte(mk(8'($urandom_range(5))));
        for (i = 0; i < 4; i++) add_byte(mk(8'($urandom_range(255))));
      end
      10: begin
        n = $urandom_range(3);
        add_byte(mk(8'h7F));
        add_byte(mk(n[7:0]));
        add_byte(mk(8'($urandom_range(127))));
        for (i = 0; i < n; i++) add_byte(mk(8'($urandom_range(255))));
      end
      11: add_byte(mk(8'hFA | 8'($urandom_range(1))));
      default: add_byte(mk(8'($urandom_range(255))));
    endcase
  endtask

  // Append one entity: header, offset size, table, then elements.
  task automatic queue_entity();
    int n, osz, i;
    n = $urandom_range(4);
    if ($urandom_range(9) == 0) begin
      add_byte(mk(8'($urandom_range(1) << 7) | 8'h7F, 1'b1));
      add_byte(mk(8'h81));
      add_byte(mk(n[7:0]));
    end else begin
      add_byte(mk(8'($urandom_range(1) << 7) | n[7:0], 1'b1));
    end
    osz = $urandom_range(2);
    add_byte(mk(osz[7:0]));
    for (i = 0; i < n * osz; i++) add_byte(mk(8'($urandom_range(255))));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1)) add_byte(mk(8'($urandom_range(6))));
      queue_value();
    end
  endtask

  int phase_no, j;
  initial begin
    errors = 0;
    tokens_seen = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    dict_size = '0;
    cust_size = '{default: '0};
    cust_mask = '0;
    phase = tvsp_pkg::PH_IDLE;
    obj = 1'b0;
    {elems, skip, acc, pay_left, comp_len} = '0;
    {nb_left, nb_idx, subtype} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of the registers and the simple tag classes.
    configure(16'hFFFF, 8'd0, 8'd255, 8'd2, 8'd1, 4'hF);
    // Empty object, then a list of every simple tag.
    add_byte(mk(8'h00, 1'b1));
    add_byte(mk(8'h00));
    add_byte(mk(8'h00));          // ignored in idle
    add_byte(mk(8'h88, 1'b1));
    add_byte(mk(8'h00));
    add_byte(mk(8'hFC));
    add_byte(mk(8'hFE));
    add_byte(mk(8'hFF));
    add_byte(mk(8'hCF));
    add_byte(mk(8'hDF));
    add_byte(mk(8'hBE));
    add_byte(mk(8'hFD));
    add_byte(mk(8'hFF));
    add_byte(mk(8'hE0));          // custom id 0, empty payload
    // Object whose offset table swallows the key bytes, then a new entity mid-entity.
    add_byte(mk(8'h01, 1'b1));
    add_byte(mk(8'hFF));
    add_byte(mk(8'h82));
    add_byte(mk(8'hFF));
    add_byte(mk(8'hFF));
    add_byte(mk(8'h81, 1'b1));
    add_byte(mk(8'h01));
    add_byte(mk(8'hFB));          // one-byte offset table
    drain();

    for (phase_no = 0; phase_no < 8; phase_no++) begin
      case (phase_no % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (phase_no == 4) configure(16'd0, 8'd255, 8'd0, 8'd0, 8'd0, 4'h0);
      else if (phase_no > 0)
        configure(16'($urandom_range(8)), 8'($urandom_range(3)), 8'($urandom_range(3)),
                  8'($urandom_range(3)), 8'($urandom_range(3)), 4'($urandom_range(15)));
      for (j = 0; j < 10; j++) begin
        if ($urandom_range(7) == 0) begin
          queue_value();                      // stray bytes and broken entities
          add_byte(mk(8'($urandom_range(255)), 1'($urandom_range(1))));
        end else begin
          queue_entity();
        end
        if (j == 7) begin
          // Hold the sender until every predicted token is out.
          while (byte_queue.size() > 0 || in_valid) @(posedge clk);
          while (token_queue.size() > 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Covered %0d tokens over eight idling and configuration phases,", tokens_seen);
    $display("including headers, keys, every value tag, payloads and all error codes.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout: run did not complete");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tvsp_pkg.sv
rtl/core/tvsp_step.sv
rtl/core/tagged_value_stream_parser.sv
sim/tagged_value_stream_parser_test.sv
